// File: sv/pcap_sd_pkg.sv
// ----------------------------------------------------------------------------
// pcap_sd_pkg
// Shared types and constants for the PCAP stream deframer.
// ----------------------------------------------------------------------------
package pcap_sd_pkg;

  // Result kinds as they appear on the output port
  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_REC       = 3'd1,
    KIND_BAD_MAGIC = 3'd2,
    KIND_BAD_LEN   = 3'd3,
    KIND_TRUNC     = 3'd4,
    KIND_END       = 3'd5
  } kind_e;

  // Parser phases
  typedef enum logic [2:0] {
    PH_FILE  = 3'd0,
    PH_REC   = 3'd1,
    PH_FRAME = 3'd2,
    PH_ERR   = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  localparam logic [4:0]  FileHdrLast = 5'd23;
  localparam logic [3:0]  RecHdrLast  = 4'd15;
  localparam logic [31:0] UsecScale   = 32'd1000;

  localparam logic [31:0] MagicUsec     = 32'hA1B2C3D4;
  localparam logic [31:0] MagicUsecSwap = 32'hD4C3B2A1;
  localparam logic [31:0] MagicNsec     = 32'hA1B23C4D;
  localparam logic [31:0] MagicNsecSwap = 32'h4D3CB2A1;

  // Command passed from the parser to the output stage
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    logic        scale;   // sub-second field is in microseconds
    logic [31:0] sec;
    logic [31:0] sub;
    logic [30:0] incl;
    logic [31:0] orig;
  } cmd_t;

endpackage

// File: sv/pcap_sd_front.sv
// ----------------------------------------------------------------------------
// pcap_sd_front
// Byte parser: collects file and record headers, classifies every stream
// byte and issues at most one command per accepted byte.
// ----------------------------------------------------------------------------
module pcap_sd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               op_i,
  input  logic [7:0]         data_byte_i,
  input  logic               signal_end_i,
  input  logic               push_ready_i,
  output logic               push_valid_o,
  output pcap_sd_pkg::cmd_t  push_cmd_o
);
  import pcap_sd_pkg::*;

  phase_e        phase_q, phase_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [31:0]   magic_q, magic_d;
  logic          swap_q, swap_d;
  logic          micro_q, micro_d;
  logic [127:0]  rec_q, rec_d;
  logic [30:0]   left_q, left_d;
  logic          started_q, started_d;

  logic          acc;
  logic          file_done, rec_done, magic_ok, magic_swap, magic_micro;
  logic [127:0]  rec_full;
  logic [31:0]   w_sec, w_sub, w_incl, w_orig;
  logic          len_bad;
  logic [30:0]   left_next;

  function automatic logic [31:0] bswap32(input logic [31:0] w, input logic en);
    bswap32 = en ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
  endfunction

  assign in_ready_o = push_ready_i;
  assign acc        = in_valid_i & push_ready_i;

  assign file_done = (cnt_q == FileHdrLast);
  assign rec_done  = (cnt_q[3:0] == RecHdrLast);

  always_comb begin
    magic_ok    = 1'b1;
    magic_swap  = 1'b0;
    magic_micro = 1'b0;
    unique case (magic_q)
      MagicUsec:     magic_micro = 1'b1;
      MagicUsecSwap: begin
        magic_swap  = 1'b1;
        magic_micro = 1'b1;
      end
      MagicNsec:     magic_micro = 1'b0;
      MagicNsecSwap: magic_swap  = 1'b1;
      default:       magic_ok    = 1'b0;
    endcase
  end

  // Last header byte comes straight from the input
  assign rec_full  = {data_byte_i, rec_q[119:0]};
  assign w_sec     = bswap32(rec_full[31:0],   swap_q);
  assign w_sub     = bswap32(rec_full[63:32],  swap_q);
  assign w_incl    = bswap32(rec_full[95:64],  swap_q);
  assign w_orig    = bswap32(rec_full[127:96], swap_q);
  assign len_bad   = w_incl[31];
  assign left_next = (left_q != '0) ? left_q - 31'd1 : left_q;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (acc) begin
      if (op_i) begin
        phase_d = PH_DONE;
      end else begin
        unique case (phase_q)
          PH_FILE: begin
            if (file_done) phase_d = magic_ok ? PH_REC : PH_ERR;
          end
          PH_REC: begin
            if (rec_done) begin
              if (len_bad)              phase_d = PH_ERR;
              else if (w_incl == '0)    phase_d = PH_REC;
              else                      phase_d = PH_FRAME;
            end
          end
          PH_FRAME: begin
            if (left_next == '0) phase_d = PH_REC;
          end
          default: phase_d = phase_q;
        endcase
      end
    end
  end

  // Header collection and command issue
  always_comb begin
    cnt_d        = cnt_q;
    magic_d      = magic_q;
    swap_d       = swap_q;
    micro_d      = micro_q;
    rec_d        = rec_q;
    left_d       = left_q;
    started_d    = started_q;
    push_valid_o = 1'b0;
    push_cmd_o   = '0;
    push_cmd_o.scale = micro_q;
    if (acc) begin
      if (op_i) begin
        if (phase_q == PH_ERR || phase_q == PH_DONE) begin
          push_valid_o = 1'b0;
        end else if (phase_q == PH_FRAME && started_q) begin
          push_valid_o    = 1'b1;
          push_cmd_o.kind = KIND_TRUNC;
        end else if (signal_end_i) begin
          push_valid_o    = 1'b1;
          push_cmd_o.kind = KIND_END;
        end
      end else begin
        unique case (phase_q)
          PH_FILE: begin
            if (cnt_q < 5'd4) begin
              magic_d[{cnt_q[1:0], 3'b000} +: 8] =
                magic_q[{cnt_q[1:0], 3'b000} +: 8] | data_byte_i;
            end
            cnt_d = cnt_q + 5'd1;
            if (file_done) begin
              cnt_d = '0;
              if (magic_ok) begin
                swap_d  = magic_swap;
                micro_d = magic_micro;
              end else begin
                push_valid_o    = 1'b1;
                push_cmd_o.kind = KIND_BAD_MAGIC;
              end
            end
          end
          PH_REC: begin
            rec_d[{cnt_q[3:0], 3'b000} +: 8] = data_byte_i;
            cnt_d = cnt_q + 5'd1;
            if (rec_done) begin
              cnt_d        = '0;
              push_valid_o = 1'b1;
              if (len_bad) begin
                push_cmd_o.kind = KIND_BAD_LEN;
              end else begin
                push_cmd_o.kind = KIND_REC;
                push_cmd_o.last = (w_incl == '0);
                push_cmd_o.sec  = w_sec;
                push_cmd_o.sub  = w_sub;
                push_cmd_o.incl = w_incl[30:0];
                push_cmd_o.orig = w_orig;
                left_d          = w_incl[30:0];
                started_d       = 1'b0;
              end
            end
          end
          PH_FRAME: begin
            push_valid_o    = 1'b1;
            push_cmd_o.kind = KIND_BYTE;
            push_cmd_o.data = data_byte_i;
            left_d          = left_next;
            started_d       = 1'b1;
            if (left_next == '0) begin
              push_cmd_o.last = 1'b1;
              started_d       = 1'b0;
            end
          end
          default: push_valid_o = 1'b0;  // drop
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_FILE;
      cnt_q     <= '0;
      magic_q   <= '0;
      swap_q    <= 1'b0;
      micro_q   <= 1'b0;
      rec_q     <= '0;
      left_q    <= '0;
      started_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      magic_q   <= magic_d;
      swap_q    <= swap_d;
      micro_q   <= micro_d;
      rec_q     <= rec_d;
      left_q    <= left_d;
      started_q <= started_d;
    end
  end

endmodule

// File: sv/pcap_sd_fifo.sv
// ----------------------------------------------------------------------------
// pcap_sd_fifo
// Short command queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module pcap_sd_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  pcap_sd_pkg::cmd_t  push_cmd_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output pcap_sd_pkg::cmd_t  pop_cmd_o
);
  import pcap_sd_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  Full     = CntW'(Depth);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != Full);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = mem_q[rd_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == LastAddr) ? '0 : wr_q + AddrW'(1);
    if (do_pop)  rd_d = (rd_q == LastAddr) ? '0 : rd_q + AddrW'(1);
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: sv/pcap_sd_back.sv
// ----------------------------------------------------------------------------
// pcap_sd_back
// Output stage: scales microsecond timestamps and holds the result register.
// ----------------------------------------------------------------------------
module pcap_sd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  pcap_sd_pkg::cmd_t  pop_cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         kind_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o,
  output logic [31:0]        ts_seconds_o,
  output logic [31:0]        ts_nanoseconds_o,
  output logic [30:0]        captured_length_o,
  output logic [31:0]        original_length_o
);
  import pcap_sd_pkg::*;

  logic        valid_q;
  logic        load;
  logic [31:0] sub_scaled;
  kind_e       kind_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [31:0] sec_q, nsec_q, orig_q;
  logic [30:0] incl_q;

  // Take the next command when the result register is empty or draining
  assign pop_ready_o = !valid_q || out_ready_i;
  assign load        = pop_valid_i & pop_ready_o;
  assign sub_scaled  = pop_cmd_i.scale ? 32'(pop_cmd_i.sub * UsecScale) : pop_cmd_i.sub;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_ready_o) begin
      valid_q <= pop_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= pop_cmd_i.kind;
      byte_q <= pop_cmd_i.data;
      last_q <= pop_cmd_i.last;
      sec_q  <= pop_cmd_i.sec;
      nsec_q <= sub_scaled;
      incl_q <= pop_cmd_i.incl;
      orig_q <= pop_cmd_i.orig;
    end
  end

  assign out_valid_o       = valid_q;
  assign kind_o            = kind_q;
  assign out_byte_o        = byte_q;
  assign last_o            = last_q;
  assign ts_seconds_o      = sec_q;
  assign ts_nanoseconds_o  = nsec_q;
  assign captured_length_o = incl_q;
  assign original_length_o = orig_q;

endmodule

// File: sv/pcap_stream_deframer_top.sv
// ----------------------------------------------------------------------------
// pcap_stream_deframer_top
// PCAP capture stream parser: file header check, record descriptors, frame
// bytes with a last flag, error and end-of-stream reporting.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one stream byte or an end
// marker (op_i = 1) per transfer. Output channel (out_valid_o/out_ready_i)
// carries at most one result per input transfer: a frame byte, a record
// descriptor (on the 16th record header byte), an error or an end report.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes signal_end; it is
// always ready; the user writes it while the block is idle (not enforced).
// Each input transfer's result passes the combinational parser, the command
// queue register and then the output register, where the timestamp
// multiply by 1000 lands. Throughput is one byte per cycle while the
// command queue has room.
// Reset returns to the file header phase with signal_end = 1 and an empty
// queue. When the receiver stalls, results collect in the queue (QueueDepth
// entries) and in_ready_o drops once it is full; nothing is lost.
// ----------------------------------------------------------------------------
module pcap_stream_deframer_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic [31:0] ts_seconds_o,
  output logic [31:0] ts_nanoseconds_o,
  output logic [30:0] captured_length_o,
  output logic [31:0] original_length_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_signal_end_i
);
  import pcap_sd_pkg::*;

  logic signal_end_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signal_end_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      signal_end_q <= cfg_signal_end_i;
    end
  end

  pcap_sd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .data_byte_i  (data_byte_i),
    .signal_end_i (signal_end_q),
    .push_ready_i (push_ready),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd)
  );

  pcap_sd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  pcap_sd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .pop_valid_i       (pop_valid),
    .pop_ready_o       (pop_ready),
    .pop_cmd_i         (pop_cmd),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .out_byte_o        (out_byte_o),
    .last_o            (last_o),
    .ts_seconds_o      (ts_seconds_o),
    .ts_nanoseconds_o  (ts_nanoseconds_o),
    .captured_length_o (captured_length_o),
    .original_length_o (original_length_o)
  );

endmodule

// File: sv/pcap_sd_checker.sv
// ----------------------------------------------------------------------------
// pcap_sd_checker
// Port-level checks for the PCAP stream deframer, bound to the top level.
// ----------------------------------------------------------------------------
module pcap_sd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  kind_o,
  input logic [7:0]  out_byte_o,
  input logic        last_o,
  input logic [30:0] captured_length_o
);
  import pcap_sd_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o))
    else $error("result dropped while stalled");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= KIND_END)
    else $error("result kind out of range");

  // Empty frame descriptor carries last
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_REC |-> last_o == (captured_length_o == '0))
    else $error("descriptor last flag mismatch");

  a_report_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_BYTE && kind_o != KIND_REC
      |-> !last_o && out_byte_o == '0)
    else $error("report carries frame data");

endmodule

bind pcap_stream_deframer_top pcap_sd_checker u_checker (.*);

// File: sim/pcap_stream_deframer_top_tb.sv
// ----------------------------------------------------------------------------
// pcap_stream_deframer_top_tb
// Drives one PCAP capture stream into the deframer. The stream is mostly
// well-formed records with random content and lengths, under random idle
// cycles on both sides. A tracker class predicts each result, and every
// result that comes out is compared with the prediction field by field.
// Each run picks its header outcome and its stream ending at random: bad
// magic, partial file or record header, truncated frame, bad length or clean end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcap_stream_deframer_top_tb;
  import pcap_sd_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  out_byte;
    logic        last;
    logic [31:0] sec;
    logic [31:0] nsec;
    logic [30:0] cap_len;
    logic [31:0] wire_len;
  } pcap_result_t;

  // Tracks the parser state and holds the results still to come out.
  class pcap_parse_tracker;
    bit           signal_end;
    phase_e       phase;
    int unsigned  hdr_cnt;
    logic [31:0]  magic;
    bit           swap;
    bit           micro;
    logic [7:0]   rec_hdr [16];
    logic [31:0]  frame_left;
    bit           frame_started;
    pcap_result_t parsed_events [$];
    int unsigned  fail_count;

    function new();
      signal_end    = 1'b1;
      phase         = PH_FILE;
      hdr_cnt       = 0;
      magic         = '0;
      swap          = 1'b0;
      micro         = 1'b0;
      frame_left    = '0;
      frame_started = 1'b0;
      fail_count    = 0;
      foreach (rec_hdr[i]) rec_hdr[i] = '0;
    endfunction

    function logic [31:0] rec_word(int i);
      logic [31:0] w;
      w = {rec_hdr[4*i+3], rec_hdr[4*i+2], rec_hdr[4*i+1], rec_hdr[4*i]};
      if (swap) w = {w[7:0], w[15:8], w[23:16], w[31:24]};
      return w;
    endfunction

    function void parse_stream_item(bit op, logic [7:0] b);
      pcap_result_t r;
      phase_e       was;
      logic [31:0]  sub;
      logic [31:0]  incl;
      r = '0;
      if (op) begin
        was   = phase;
        phase = PH_DONE;
        if (was == PH_ERR || was == PH_DONE) return;
        if (was == PH_FRAME && frame_started) begin
          r.kind = KIND_TRUNC;
          parsed_events.push_back(r);
        end else if (signal_end) begin
          r.kind = KIND_END;
          parsed_events.push_back(r);
        end
        return;
      end
      case (phase)
        PH_FILE: begin
          if (hdr_cnt < 4) magic[8*hdr_cnt +: 8] = b;
          hdr_cnt++;
          if (hdr_cnt == 24) begin
            hdr_cnt = 0;
            phase   = PH_REC;
            case (magic)
              MagicUsec:     begin swap = 1'b0; micro = 1'b1; end
              MagicUsecSwap: begin swap = 1'b1; micro = 1'b1; end
              MagicNsec:     begin swap = 1'b0; micro = 1'b0; end
              MagicNsecSwap: begin swap = 1'b1; micro = 1'b0; end
              default: begin
                phase  = PH_ERR;
                r.kind = KIND_BAD_MAGIC;
                parsed_events.push_back(r);
              end
            endcase
          end
        end
        PH_REC: begin
          rec_hdr[hdr_cnt] = b;
          hdr_cnt++;
          if (hdr_cnt == 16) begin
            hdr_cnt = 0;
            sub     = rec_word(1);
            incl    = rec_word(2);
            if (micro) sub = sub * UsecScale;
            if (incl[31]) begin
              phase  = PH_ERR;
              r.kind = KIND_BAD_LEN;
            end else begin
              r.kind        = KIND_REC;
              r.last        = (incl == 0);
              r.sec         = rec_word(0);
              r.nsec        = sub;
              r.cap_len     = incl[30:0];
              r.wire_len    = rec_word(3);
              frame_left    = incl;
              frame_started = 1'b0;
              phase         = (incl == 0) ? PH_REC : PH_FRAME;
            end
            parsed_events.push_back(r);
          end
        end
        PH_FRAME: begin
          r.kind     = KIND_BYTE;
          r.out_byte = b;
          if (frame_left > 0) frame_left--;
          frame_started = 1'b1;
          if (frame_left == 0) begin
            r.last        = 1'b1;
            frame_started = 1'b0;
            phase         = PH_REC;
          end
          parsed_events.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void note_input(bit op, logic [7:0] b);
      parse_stream_item(op, b);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(pcap_result_t got);
      pcap_result_t want;
      if (parsed_events.size() == 0) begin
        $error("kind: expected no result, got %0d", got.kind);
        fail_count++;
        return;
      end
      want = parsed_events.pop_front();
      cmp("kind", 32'(want.kind), 32'(got.kind));
      cmp("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      cmp("last", 32'(want.last), 32'(got.last));
      cmp("ts_seconds", want.sec, got.sec);
      cmp("ts_nanoseconds", want.nsec, got.nsec);
      cmp("captured_length", 32'(want.cap_len), 32'(got.cap_len));
      cmp("original_length", want.wire_len, got.wire_len);
    endfunction
  endclass

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_op          = 1'b0;
  logic [7:0]  in_byte        = '0;
  logic        out_ready      = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic        cfg_signal_end = 1'b0;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [2:0]  kind_o;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic [31:0] ts_seconds_o;
  logic [31:0] ts_nanoseconds_o;
  logic [30:0] captured_length_o;
  logic [31:0] original_length_o;
  logic        cfg_ready_o;

  pcap_parse_tracker tracker = new();
  bit          in_burst     = 1'b0;
  bit          out_burst    = 1'b0;
  bit          stream_swap  = 1'b0;
  int unsigned stream_bytes = 0;

  pcap_stream_deframer_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready_o),
    .op_i              (in_op),
    .data_byte_i       (in_byte),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready),
    .kind_o            (kind_o),
    .out_byte_o        (out_byte_o),
    .last_o            (last_o),
    .ts_seconds_o      (ts_seconds_o),
    .ts_nanoseconds_o  (ts_nanoseconds_o),
    .captured_length_o (captured_length_o),
    .original_length_o (original_length_o),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_signal_end_i  (cfg_signal_end)
  );

  always #4 clk_i = ~clk_i;

  // Keep valid high across back-to-back transfers; drop it only for a gap.
  task automatic send_item(input bit op, input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_byte  <= b;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    tracker.note_input(op, b);
    if (!op) stream_bytes++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) begin
      send_item(1'b0, stream_swap ? w[8*(3-i) +: 8] : w[8*i +: 8]);
    end
  endtask

  // Magic goes out little-endian; the rest of the file header is filler.
  task automatic send_file_header(input logic [31:0] m, input int unsigned len);
    for (int i = 0; i < len; i++) begin
      send_item(1'b0, (i < 4) ? m[8*i +: 8] : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_record(input logic [31:0] sec, input logic [31:0] sub,
                             input logic [31:0] incl, input logic [31:0] orig);
    send_word(sec);
    send_word(sub);
    send_word(incl);
    send_word(orig);
  endtask

  task automatic send_frame(input int unsigned n);
    repeat (n) send_item(1'b0, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_rand_record();
    logic [31:0] incl;
    logic [31:0] sub;
    logic [31:0] orig;
    case ($urandom_range(0, 19))
      0:       incl = '0;
      1:       incl = $urandom_range(100, 300);
      default: incl = $urandom_range(1, 16);
    endcase
    case ($urandom_range(0, 3))
      0:       sub = $urandom();
      1:       sub = '0;
      2:       sub = '1;
      default: sub = $urandom_range(0, 999999999);
    endcase
    orig = $urandom_range(0, 1) ? incl + $urandom_range(0, 64) : $urandom();
    send_record($urandom(), sub, incl, orig);
    send_frame(incl);
  endtask

  // Hold the input until every predicted result is out and the pipe is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.parsed_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_signal_end(input bit v);
    cfg_valid      <= 1'b1;
    cfg_signal_end <= v;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    tracker.signal_end = v;
    cfg_valid <= 1'b0;
  endtask

  // Result side: random ready gaps, check every transfer.
  initial begin
    pcap_result_t got;
    int unsigned  gap;
    wait (rst_ni === 1'b1);
    forever begin
      if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      got.kind     = kind_e'(kind_o);
      got.out_byte = out_byte_o;
      got.last     = last_o;
      got.sec      = ts_seconds_o;
      got.nsec     = ts_nanoseconds_o;
      got.cap_len  = captured_length_o;
      got.wire_len = original_length_o;
      tracker.check_result(got);
    end
  end

  initial begin
    int unsigned hdr_mode;
    int unsigned term;
    int unsigned n;
    int unsigned next_pause;
    int unsigned guard;
    logic [31:0] magic;
    logic [31:0] incl;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_signal_end(1'b0);

    case ($urandom_range(0, 3))
      0:       begin magic = MagicUsec;     stream_swap = 1'b0; end
      1:       begin magic = MagicUsecSwap; stream_swap = 1'b1; end
      2:       begin magic = MagicNsec;     stream_swap = 1'b0; end
      default: begin magic = MagicNsecSwap; stream_swap = 1'b1; end
    endcase
    hdr_mode = $urandom_range(0, 15);

    if (hdr_mode == 0) begin
      // one flipped bit makes the magic unknown; the rest is dropped
      send_file_header(magic ^ (32'h1 << $urandom_range(0, 31)), 24);
      send_frame($urandom_range(900, 940));
    end else if (hdr_mode == 1) begin
      send_file_header(magic, $urandom_range(0, 23));
    end else begin
      send_file_header(magic, 24);
      // empty frame with all-ones fields, then short frames with edge bytes
      send_record('1, '1, '0, '1);
      send_record('0, '0, 32'd1, '0);
      send_item(1'b0, 8'hFF);
      send_record($urandom(), 32'd999999, 32'd2, 32'd60);
      send_item(1'b0, 8'h00);
      send_item(1'b0, 8'hAA);
      wait_idle();
      write_signal_end(1'b1);

      next_pause = stream_bytes + 250;
      while (stream_bytes < 950) begin
        if (stream_bytes >= next_pause) begin
          wait_idle();
          write_signal_end(1'($urandom_range(0, 1)));
          next_pause += 250;
        end
        send_rand_record();
      end
    end

    wait_idle();
    write_signal_end(1'($urandom_range(0, 1)));

    if (hdr_mode > 1) begin
      term = $urandom_range(0, 4);
      case (term)
        1: begin
          // cut inside a record header
          send_frame($urandom_range(1, 15));
        end
        2: begin
          // cut inside a frame, short or near the length limit
          if ($urandom_range(0, 1)) incl = $urandom_range(2, 40);
          else incl = {1'b0, 31'($urandom())} | 32'h4000_0000;
          send_record($urandom(), $urandom(), incl, $urandom());
          n = (incl - 1 < 8) ? incl - 1 : 8;
          send_frame($urandom_range(1, n));
        end
        3: begin
          // descriptor out, no frame byte yet
          send_record($urandom(), $urandom(), $urandom_range(1, 100), $urandom());
        end
        4: begin
          send_record($urandom(), $urandom(), 32'h8000_0000 | $urandom(), $urandom());
          send_frame($urandom_range(0, 20));
        end
        default: ;
      endcase
    end

    send_item(1'b1, 8'($urandom_range(0, 255)));
    // everything past the end marker is ignored
    n = (hdr_mode == 1) ? $urandom_range(900, 940) : $urandom_range(3, 8);
    repeat (n) begin
      send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
    in_valid <= 1'b0;

    guard = 0;
    while (tracker.parsed_events.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    if (tracker.parsed_events.size() != 0) begin
      $error("%0d predicted results never came out", tracker.parsed_events.size());
      tracker.fail_count++;
    end
    if (tracker.fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
sv/pcap_sd_pkg.sv
sv/pcap_sd_front.sv
sv/pcap_sd_fifo.sv
sv/pcap_sd_back.sv
sv/pcap_stream_deframer_top.sv
sv/pcap_sd_checker.sv
sim/pcap_stream_deframer_top_tb.sv
